/* rtl/aavr_pkg.sv */
package aavr_pkg;

  // Internal fixed-point word for Q2.30 values, with headroom for 2*s^2 up to 2.0
  localparam int QW = 34;

  localparam int AXIS_BITS    = 16;
  localparam int SQRT_STEPS   = 30;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 24;

  localparam logic signed [QW-1:0] ONE_Q30     = QW'(64'sd1073741824);
  localparam logic signed [31:0]   CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [32:0]   QUARTER_TURN = 33'sd1073741824;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Q2.30 product, floor
  function automatic logic signed [QW-1:0] mul30(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[QW+29:30];
  endfunction

endpackage

/* rtl/aavr_row.sv */
// One matrix row times the vector: split multiply, sum, floor shift, saturate.
module aavr_row import aavr_pkg::*; #(
  parameter int VEC_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [QW-1:0]        row [3],
  input  logic signed [VEC_WIDTH-1:0] vec [3],
  input  logic                        pass,
  input  logic signed [VEC_WIDTH-1:0] pass_val,
  output logic signed [VEC_WIDTH-1:0] res
);

  localparam int VW = VEC_WIDTH;
  localparam int H  = VW / 2;
  localparam int HW = VW - H;
  localparam int AW = QW + VW + 3;

  localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

  logic signed [QW+HW-1:0] ph_r [3];
  logic signed [QW+H:0]    pl_r [3];
  logic signed [AW-1:0]    acc_r, acc_nxt;
  logic                    pass_d1_r, pass_d2_r;
  logic signed [VW-1:0]    pval_d1_r, pval_d2_r;
  logic signed [AW-1:0]    sh;
  logic                    fits;

  // products against the signed upper half and unsigned lower half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= row[j] * $signed(vec[j][VW-1:H]);
        pl_r[j] <= row[j] * $signed({1'b0, vec[j][H-1:0]});
      end
      pass_d1_r <= pass;
      pval_d1_r <= pass_val;
    end
  end

  always_comb begin
    logic signed [AW-1:0] hi_ext;
    logic signed [AW-1:0] lo_ext;
    acc_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      hi_ext  = ph_r[j];
      lo_ext  = pl_r[j];
      acc_nxt = acc_nxt + (hi_ext <<< H) + lo_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r     <= acc_nxt;
      pass_d2_r <= pass_d1_r;
      pval_d2_r <= pval_d1_r;
    end
  end

  assign sh   = acc_r >>> 30;
  assign fits = (&sh[AW-1:VW-1]) | ~(|sh[AW-1:VW-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (pass_d2_r) begin
        res <= pval_d2_r;
      end else if (fits) begin
        res <= sh[VW-1:0];
      end else begin
        res <= acc_r[AW-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

endmodule

/* rtl/axis_angle_vector_rotation.sv */
// Axis-angle vector rotation. Each request carries a Q16.16 vector, an angle as a
// fraction of a full turn (2^ANGLE_BITS = one turn), a Q1.14 axis of any length and,
// in in_tuser, a flag choosing the rotation or its transpose (the inverse rotation).
// The axis is normalised inside (pipelined bit-per-stage square root, then three
// pipelined restoring dividers), sin/cos of the half angle come from a 24-stage
// CORDIC running alongside the root, the half-angle matrix
// R = I - 2s^2(I - nn^T) + 2sc[n]x is built and applied, and each component is
// floored and saturated to VEC_WIDTH bits. A zero axis passes the vector through
// unchanged with out_tuser (axis error) set. Throughput is one request per clock;
// latency is set by the 30 root stages, the 31 divider stages and the
// multiply/matrix stages behind them. The whole pipeline advances together: it
// holds only while a result sits on the output unaccepted.
module axis_angle_vector_rotation import aavr_pkg::*; #(
  parameter int VEC_WIDTH  = 32,
  parameter int ANGLE_BITS = 16,
  localparam int IN_TW  = ((3 * VEC_WIDTH + ANGLE_BITS + 3 * AXIS_BITS + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * VEC_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // vec_x, vec_y, vec_z, turn_angle, axis_x, axis_y, axis_z, zero pad
  input  logic [IN_TW-1:0]  in_tdata,
  // use_transpose
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // rot_x, rot_y, rot_z, zero pad
  output logic [OUT_TW-1:0] out_tdata,
  // axis_error
  output logic              out_tuser
);

  localparam int VW = VEC_WIDTH;
  localparam int AB = ANGLE_BITS;

  // stage map
  localparam int S_DIV0 = SQRT_STEPS + 1;        // root done, divider loaded
  localparam int S_N    = S_DIV0 + DIV_STEPS + 1; // signed unit axis
  localparam int NS     = S_N + 7;                // products, terms, matrix, 3 in row unit

  // product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;

  logic          en;
  logic [NS-1:0] valid_r;

  // whole pipe moves unless the output holds an untaken result
  assign en         = !valid_r[NS-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = valid_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NS-2:0], in_tvalid};
    end
  end

  // ---------------- input unpack ----------------
  logic signed [VW-1:0] in_vec  [3];
  logic signed [15:0]   in_axis [3];
  logic [AB-1:0]        in_angle;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_vec[i]  = in_tdata[i*VW +: VW];
      in_axis[i] = in_tdata[3*VW + AB + 16*i +: 16];
    end
    in_angle = in_tdata[3*VW +: AB];
  end

  // ---------------- root / CORDIC segment ----------------
  logic signed [VW-1:0] a_vec_r  [0:SQRT_STEPS][3];
  logic                 a_tr_r   [0:SQRT_STEPS];
  logic                 a_zero_r [0:SQRT_STEPS];
  logic [15:0]          a_mag_r  [0:SQRT_STEPS][3];
  logic                 a_neg_r  [0:SQRT_STEPS][3];
  logic [59:0]          a_sqv_r  [0:SQRT_STEPS];
  logic [33:0]          a_rem_r  [0:SQRT_STEPS];
  logic [31:0]          a_root_r [0:SQRT_STEPS];
  logic signed [31:0]   a_cx_r   [0:SQRT_STEPS];
  logic signed [31:0]   a_cy_r   [0:SQRT_STEPS];
  logic signed [32:0]   a_z_r    [0:SQRT_STEPS];

  logic signed [31:0] sq_nxt [3];
  logic [31:0]        sumsq_nxt;
  logic [31:0]        phase_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = in_axis[i] * in_axis[i];
    end
    sumsq_nxt = $unsigned(sq_nxt[0]) + $unsigned(sq_nxt[1]) + $unsigned(sq_nxt[2]);
    phase_nxt = 32'(in_angle) << (32 - AB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_vec_r[0][i] <= in_vec[i];
        a_mag_r[0][i] <= in_axis[i][15] ? 16'(-in_axis[i]) : 16'(in_axis[i]);
        a_neg_r[0][i] <= in_axis[i][15];
      end
      a_tr_r[0]   <= in_tuser;
      a_zero_r[0] <= (sumsq_nxt == 32'd0);
      a_sqv_r[0]  <= {sumsq_nxt, 28'd0};
      a_rem_r[0]  <= '0;
      a_root_r[0] <= '0;
      a_cx_r[0]   <= '0;
      a_cy_r[0]   <= CORDIC_GAIN;
      // half angle, measured from a quarter turn
      a_z_r[0]    <= $signed({2'b00, phase_nxt[31:1]}) - QUARTER_TURN;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_root
    localparam int J = k - 1;
    logic [33:0]        r2, trial, rem_nxt;
    logic [31:0]        root_nxt;
    logic signed [31:0] cx_nxt, cy_nxt;
    logic signed [32:0] z_nxt;

    always_comb begin
      r2    = {a_rem_r[k-1][31:0], a_sqv_r[k-1][59-2*J -: 2]};
      trial = {a_root_r[k-1], 2'b01};
      if (r2 >= trial) begin
        rem_nxt  = r2 - trial;
        root_nxt = {a_root_r[k-1][30:0], 1'b1};
      end else begin
        rem_nxt  = r2;
        root_nxt = {a_root_r[k-1][30:0], 1'b0};
      end
    end

    if (J < CORDIC_STEPS) begin : g_cordic
      always_comb begin
        if (!a_z_r[k-1][32]) begin
          cx_nxt = a_cx_r[k-1] - (a_cy_r[k-1] >>> J);
          cy_nxt = a_cy_r[k-1] + (a_cx_r[k-1] >>> J);
          z_nxt  = a_z_r[k-1] - $signed({1'b0, atan_turn(5'(J))});
        end else begin
          cx_nxt = a_cx_r[k-1] + (a_cy_r[k-1] >>> J);
          cy_nxt = a_cy_r[k-1] - (a_cx_r[k-1] >>> J);
          z_nxt  = a_z_r[k-1] + $signed({1'b0, atan_turn(5'(J))});
        end
      end
    end else begin : g_hold
      always_comb begin
        cx_nxt = a_cx_r[k-1];
        cy_nxt = a_cy_r[k-1];
        z_nxt  = a_z_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_vec_r[k]  <= a_vec_r[k-1];
        a_tr_r[k]   <= a_tr_r[k-1];
        a_zero_r[k] <= a_zero_r[k-1];
        a_mag_r[k]  <= a_mag_r[k-1];
        a_neg_r[k]  <= a_neg_r[k-1];
        a_sqv_r[k]  <= a_sqv_r[k-1];
        a_rem_r[k]  <= rem_nxt;
        a_root_r[k] <= root_nxt;
        a_cx_r[k]   <= cx_nxt;
        a_cy_r[k]   <= cy_nxt;
        a_z_r[k]    <= z_nxt;
      end
    end
  end

  // ---------------- divider segment ----------------
  logic signed [VW-1:0] b_vec_r  [0:DIV_STEPS][3];
  logic                 b_tr_r   [0:DIV_STEPS];
  logic                 b_zero_r [0:DIV_STEPS];
  logic                 b_neg_r  [0:DIV_STEPS][3];
  logic [29:0]          b_len_r  [0:DIV_STEPS];
  logic signed [QW-1:0] b_k1_r   [0:DIV_STEPS];
  logic signed [QW-1:0] b_k2_r   [0:DIV_STEPS];
  logic [29:0]          b_rem_r  [0:DIV_STEPS][3];
  logic [30:0]          b_q_r    [0:DIV_STEPS][3];

  logic signed [63:0] cc_nxt, cs_nxt;

  assign cc_nxt = a_cy_r[SQRT_STEPS] * a_cy_r[SQRT_STEPS];
  assign cs_nxt = a_cy_r[SQRT_STEPS] * a_cx_r[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      b_vec_r[0]  <= a_vec_r[SQRT_STEPS];
      b_tr_r[0]   <= a_tr_r[SQRT_STEPS];
      b_zero_r[0] <= a_zero_r[SQRT_STEPS];
      b_neg_r[0]  <= a_neg_r[SQRT_STEPS];
      b_len_r[0]  <= a_root_r[SQRT_STEPS][29:0];
      // k1 = 2 s^2, k2 = 2 s c
      b_k1_r[0]   <= cc_nxt[QW+28:29];
      b_k2_r[0]   <= cs_nxt[QW+28:29];
      for (int i = 0; i < 3; i++) begin
        // |a| << 44 with the low quotient bits all zero: start from |a| << 13
        b_rem_r[0][i] <= {1'b0, a_mag_r[SQRT_STEPS][i], 13'd0};
        b_q_r[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [30:0] r2  [3];
    logic        ge  [3];
    logic [29:0] rem_nxt [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i]      = {b_rem_r[k-1][i], 1'b0};
        ge[i]      = r2[i] >= {1'b0, b_len_r[k-1]};
        rem_nxt[i] = ge[i] ? 30'(r2[i] - {1'b0, b_len_r[k-1]}) : r2[i][29:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        b_vec_r[k]  <= b_vec_r[k-1];
        b_tr_r[k]   <= b_tr_r[k-1];
        b_zero_r[k] <= b_zero_r[k-1];
        b_neg_r[k]  <= b_neg_r[k-1];
        b_len_r[k]  <= b_len_r[k-1];
        b_k1_r[k]   <= b_k1_r[k-1];
        b_k2_r[k]   <= b_k2_r[k-1];
        for (int i = 0; i < 3; i++) begin
          b_rem_r[k][i] <= rem_nxt[i];
          b_q_r[k][i]   <= {b_q_r[k-1][i][29:0], ge[i]};
        end
      end
    end
  end

  // ---------------- unit axis ----------------
  logic signed [QW-1:0] c_n_r [3];
  logic signed [VW-1:0] c_vec_r [3];
  logic                 c_tr_r, c_zero_r;
  logic signed [QW-1:0] c_k1_r, c_k2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_n_r[i] <= b_neg_r[DIV_STEPS][i] ? -$signed({3'b000, b_q_r[DIV_STEPS][i]})
                                          :  $signed({3'b000, b_q_r[DIV_STEPS][i]});
      end
      c_vec_r  <= b_vec_r[DIV_STEPS];
      c_tr_r   <= b_tr_r[DIV_STEPS];
      c_zero_r <= b_zero_r[DIV_STEPS];
      c_k1_r   <= b_k1_r[DIV_STEPS];
      c_k2_r   <= b_k2_r[DIV_STEPS];
    end
  end

  // ---------------- n n^T and n k2 ----------------
  logic signed [QW-1:0] d_nn_r [6];
  logic signed [QW-1:0] d_nk_r [3];
  logic signed [VW-1:0] d_vec_r [3];
  logic                 d_tr_r, d_zero_r;
  logic signed [QW-1:0] d_k1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_nn_r[P_XX] <= mul30(c_n_r[0], c_n_r[0]);
      d_nn_r[P_YY] <= mul30(c_n_r[1], c_n_r[1]);
      d_nn_r[P_ZZ] <= mul30(c_n_r[2], c_n_r[2]);
      d_nn_r[P_XY] <= mul30(c_n_r[0], c_n_r[1]);
      d_nn_r[P_XZ] <= mul30(c_n_r[0], c_n_r[2]);
      d_nn_r[P_YZ] <= mul30(c_n_r[1], c_n_r[2]);
      for (int i = 0; i < 3; i++) begin
        d_nk_r[i] <= mul30(c_n_r[i], c_k2_r);
      end
      d_vec_r  <= c_vec_r;
      d_tr_r   <= c_tr_r;
      d_zero_r <= c_zero_r;
      d_k1_r   <= c_k1_r;
    end
  end

  // ---------------- k1 terms ----------------
  logic signed [QW-1:0] e_t_r [6];
  logic signed [QW-1:0] e_nk_r [3];
  logic signed [QW-1:0] e_diag_r;
  logic signed [VW-1:0] e_vec_r [3];
  logic                 e_tr_r, e_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 6; p++) begin
        e_t_r[p] <= mul30(d_nn_r[p], d_k1_r);
      end
      e_nk_r   <= d_nk_r;
      e_diag_r <= ONE_Q30 - d_k1_r;
      e_vec_r  <= d_vec_r;
      e_tr_r   <= d_tr_r;
      e_zero_r <= d_zero_r;
    end
  end

  // ---------------- matrix, optionally transposed ----------------
  logic signed [QW-1:0] m_nxt [3][3];
  logic signed [QW-1:0] f_m_r [3][3];
  logic signed [VW-1:0] f_vec_r [3];
  logic                 f_zero_r;

  always_comb begin
    m_nxt[0][0] = e_diag_r + e_t_r[P_XX];
    m_nxt[1][1] = e_diag_r + e_t_r[P_YY];
    m_nxt[2][2] = e_diag_r + e_t_r[P_ZZ];
    m_nxt[0][1] = e_t_r[P_XY] - e_nk_r[2];
    m_nxt[1][0] = e_t_r[P_XY] + e_nk_r[2];
    m_nxt[0][2] = e_t_r[P_XZ] + e_nk_r[1];
    m_nxt[2][0] = e_t_r[P_XZ] - e_nk_r[1];
    m_nxt[1][2] = e_t_r[P_YZ] - e_nk_r[0];
    m_nxt[2][1] = e_t_r[P_YZ] + e_nk_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          f_m_r[i][j] <= e_tr_r ? m_nxt[j][i] : m_nxt[i][j];
        end
      end
      f_vec_r  <= e_vec_r;
      f_zero_r <= e_zero_r;
    end
  end

  // ---------------- row units ----------------
  logic signed [VW-1:0] rot [3];
  logic                 err_d_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    aavr_row #(
      .VEC_WIDTH (VW)
    ) u_row (
      .clk      (clk),
      .en       (en),
      .row      (f_m_r[i]),
      .vec      (f_vec_r),
      .pass     (f_zero_r),
      .pass_val (f_vec_r[i]),
      .res      (rot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_d_r[0] <= f_zero_r;
      err_d_r[1] <= err_d_r[0];
      err_d_r[2] <= err_d_r[1];
    end
  end

  assign out_tdata = OUT_TW'({rot[2], rot[1], rot[0]});
  assign out_tuser = err_d_r[2];

  // ---------------- checks ----------------
  // a non-zero axis always gives a root of at least 2^14
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[S_DIV0] && !b_zero_r[0] |-> b_len_r[0][29:14] != 16'd0)
    else $error("axis length zero for non-zero axis");

  // 2 s^2 can never be negative
  a_k1_sign: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[S_DIV0] |-> !b_k1_r[0][QW-1])
    else $error("negative k1");

  // a held pipeline neither drops nor creates requests
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r))
    else $error("valid bits moved during stall");

  // a request in the last divider stage is always loaded into the unit axis when the pipe moves
  a_unit_follow: assert property (@(posedge clk) disable iff (!rst_n)
    en && valid_r[S_N-1] |=> valid_r[S_N])
    else $error("request lost between divider and unit axis");

endmodule
